### sv/rmsedf_pkg.sv
package rmsedf_pkg;

  // Fixed field widths of the item and result words
  localparam int TASK_W = 3;
  localparam int WORD_W = 32;
  localparam int MASK_W = 8;
  localparam int CFG_W  = 4;

  // Configuration register indexes
  localparam logic CFG_MODE  = 1'b0;
  localparam logic CFG_COUNT = 1'b1;

  // Item actions
  localparam logic ACT_TICK = 1'b0;
  localparam logic ACT_LOAD = 1'b1;

  // Scheduler modes
  localparam logic MODE_RM  = 1'b0;
  localparam logic MODE_EDF = 1'b1;

  typedef struct packed {
    logic capture;  // take the input word into the item registers
    logic load;     // write the task table entry
    logic step;     // process one table entry of the scan
    logic finish;   // build the result word and commit the tick
  } ctrl_cmd_t;

  typedef struct packed {
    logic new_load;   // word on the input port is a load
    logic new_empty;  // no entry takes part in scheduling
    logic scan_last;  // current scan entry is the last one
    logic out_free;   // result register can take a new word
  } ctrl_sts_t;

endpackage

### sv/rmsedf_ctrl.sv
module rmsedf_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  rmsedf_pkg::ctrl_sts_t sts_i,
  output rmsedf_pkg::ctrl_cmd_t cmd_o
);
  import rmsedf_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOAD = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0] state_q, state_d;

  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          if (sts_i.new_load) begin
            state_d = ST_LOAD;
          end else if (sts_i.new_empty) begin
            state_d = ST_FIN;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_LOAD: begin
        cmd_o.load = 1'b1;
        state_d    = ST_FIN;
      end
      ST_SCAN: begin
        cmd_o.step = 1'b1;
        if (sts_i.scan_last) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        // hold until the result register is free
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### sv/rmsedf_dp.sv
module rmsedf_dp #(
  parameter int TASK_SLOTS = 8,
  parameter int TIME_BITS  = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  rmsedf_pkg::ctrl_cmd_t             cmd_i,
  output rmsedf_pkg::ctrl_sts_t             sts_o,
  input  logic                              cfg_we_i,
  input  logic                              cfg_index_i,
  input  logic [rmsedf_pkg::CFG_W-1:0]      cfg_data_i,
  input  logic                              action_i,
  input  logic [rmsedf_pkg::TASK_W-1:0]     task_index_i,
  input  logic [rmsedf_pkg::WORD_W-1:0]     task_period_i,
  input  logic [rmsedf_pkg::WORD_W-1:0]     task_deadline_i,
  input  logic [rmsedf_pkg::WORD_W-1:0]     first_release_i,
  input  logic                              job_done_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [rmsedf_pkg::TASK_W-1:0]     served_task_o,
  output logic                              idle_o,
  output logic                              preempted_o,
  output logic [rmsedf_pkg::TASK_W-1:0]     preempted_task_o,
  output logic [rmsedf_pkg::MASK_W-1:0]     released_mask_o,
  output logic [rmsedf_pkg::MASK_W-1:0]     dropped_mask_o,
  output logic                              completed_o,
  output logic [rmsedf_pkg::WORD_W-1:0]     response_time_o,
  output logic                              late_o
);
  import rmsedf_pkg::*;

  localparam int IDX_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int CNT_W = $clog2(TASK_SLOTS + 1);
  localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

  function automatic logic [TIME_BITS-1:0] sat_add(input logic [TIME_BITS-1:0] a,
                                                   input logic [TIME_BITS-1:0] b);
    logic [TIME_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_BITS] ? TIME_MAX : s[TIME_BITS-1:0];
  endfunction

  // configuration
  logic             mode_q;
  logic [CFG_W-1:0] count_q;
  logic [4:0]       cnt_wide;
  logic [CNT_W-1:0] cnt_lim;

  // item registers
  logic                 act_q;
  logic [IDX_W-1:0]     idx_q, idx_d;
  logic [TIME_BITS-1:0] per_q, dl_q, fr_q;
  logic                 done_q;
  logic [4:0]           red;

  // task table and job state
  logic [TIME_BITS-1:0] per_mem [TASK_SLOTS];
  logic [TIME_BITS-1:0] dl_mem  [TASK_SLOTS];
  logic [TIME_BITS-1:0] nr_mem  [TASK_SLOTS];
  logic [TIME_BITS-1:0] rt_mem  [TASK_SLOTS];
  logic [TIME_BITS-1:0] ad_mem  [TASK_SLOTS];
  logic [TASK_SLOTS-1:0] active_q;

  logic [TIME_BITS-1:0] time_q;
  logic                 run_valid_q;
  logic [IDX_W-1:0]     run_idx_q;
  logic                 run_act_q;

  // scan state
  logic [IDX_W-1:0]     scan_q;
  logic [MASK_W-1:0]    rel_q, drop_q;
  logic                 have_q;
  logic [IDX_W-1:0]     best_idx_q;
  logic [TIME_BITS-1:0] best_key_q, best_rt_q, best_ad_q;

  // scan entry evaluation
  logic [TIME_BITS-1:0] per_rd, dl_rd, nr_rd, rt_rd, ad_rd;
  logic                 hit, act_new, win;
  logic [TIME_BITS-1:0] rt_new, ad_new, nr_new, key_new;
  logic [MASK_W-1:0]    bit_sel;

  // finish
  logic [TIME_BITS-1:0] done_t, resp_t;
  logic                 preempt, complete;

  logic                 out_valid_q;

  assign cnt_wide = ({1'b0, count_q} > 5'(TASK_SLOTS)) ? 5'(TASK_SLOTS) : {1'b0, count_q};
  assign cnt_lim  = CNT_W'(cnt_wide);

  // reduce the table index modulo the slot count
  always_comb begin
    red = 5'(task_index_i);
    for (int s = 0; s < 7; s++) begin
      if (red >= 5'(TASK_SLOTS)) begin
        red = red - 5'(TASK_SLOTS);
      end
    end
    idx_d = IDX_W'(red);
  end

  assign sts_o.new_load  = (action_i == ACT_LOAD);
  assign sts_o.new_empty = (cnt_lim == '0);
  assign sts_o.scan_last = ((CNT_W'(scan_q) + CNT_W'(1)) == cnt_lim);
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

  assign per_rd = per_mem[scan_q];
  assign dl_rd  = dl_mem[scan_q];
  assign nr_rd  = nr_mem[scan_q];
  assign rt_rd  = rt_mem[scan_q];
  assign ad_rd  = ad_mem[scan_q];

  always_comb begin
    hit     = (time_q == nr_rd);
    act_new = active_q[scan_q] | hit;
    rt_new  = hit ? time_q : rt_rd;
    ad_new  = hit ? sat_add(time_q, dl_rd) : ad_rd;
    nr_new  = sat_add(nr_rd, per_rd);
    key_new = (mode_q == MODE_EDF) ? ad_new : per_rd;
    // ascending scan: an equal key never beats the lower index already held
    win     = act_new && (rt_new <= time_q) && (!have_q || (key_new < best_key_q));
    bit_sel = MASK_W'(1) << scan_q;
  end

  always_comb begin
    done_t   = sat_add(time_q, TIME_BITS'(1));
    resp_t   = done_t - best_rt_q;
    preempt  = run_valid_q && have_q && (run_idx_q != best_idx_q) && run_act_q;
    complete = have_q && done_q;
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_RM;
      count_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_MODE:  mode_q  <= cfg_data_i[0];
        CFG_COUNT: count_q <= cfg_data_i;
        default:   ;
      endcase
    end
  end

  // item capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      act_q  <= action_i;
      idx_q  <= idx_d;
      per_q  <= TIME_BITS'(task_period_i);
      dl_q   <= TIME_BITS'(task_deadline_i);
      fr_q   <= TIME_BITS'(first_release_i);
      done_q <= job_done_i;
    end
  end

  // table storage
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      per_mem[idx_q] <= per_q;
      dl_mem[idx_q]  <= dl_q;
      nr_mem[idx_q]  <= fr_q;
    end else if (cmd_i.step && hit) begin
      nr_mem[scan_q] <= nr_new;
      rt_mem[scan_q] <= rt_new;
      ad_mem[scan_q] <= ad_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
    end else if (cmd_i.load) begin
      active_q[idx_q] <= 1'b0;
    end else if (cmd_i.step && hit) begin
      active_q[scan_q] <= 1'b1;
    end else if (cmd_i.finish && (act_q == ACT_TICK) && complete) begin
      active_q[best_idx_q] <= 1'b0;
    end
  end

  // scan bookkeeping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q <= 1'b0;
    end else if (cmd_i.capture) begin
      have_q <= 1'b0;
    end else if (cmd_i.step && win) begin
      have_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      scan_q    <= '0;
      rel_q     <= '0;
      drop_q    <= '0;
      run_act_q <= run_valid_q && active_q[run_idx_q];
    end else if (cmd_i.step) begin
      scan_q <= scan_q + IDX_W'(1);
      if (hit) begin
        rel_q <= rel_q | bit_sel;
        if (active_q[scan_q]) begin
          drop_q <= drop_q | bit_sel;
        end
      end
      if (win) begin
        best_idx_q <= scan_q;
        best_key_q <= key_new;
        best_rt_q  <= rt_new;
        best_ad_q  <= ad_new;
      end
      if (scan_q == run_idx_q) begin
        run_act_q <= act_new;
      end
    end
  end

  // tick commit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q      <= '0;
      run_valid_q <= 1'b0;
    end else if (cmd_i.finish && (act_q == ACT_TICK)) begin
      time_q      <= done_t;
      run_valid_q <= have_q && !done_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish && (act_q == ACT_TICK)) begin
      run_idx_q <= best_idx_q;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      if (act_q == ACT_LOAD) begin
        served_task_o    <= '0;
        idle_o           <= 1'b0;
        preempted_o      <= 1'b0;
        preempted_task_o <= '0;
        released_mask_o  <= '0;
        dropped_mask_o   <= '0;
        completed_o      <= 1'b0;
        response_time_o  <= '0;
        late_o           <= 1'b0;
      end else begin
        served_task_o    <= have_q ? TASK_W'(best_idx_q) : '0;
        idle_o           <= !have_q;
        preempted_o      <= preempt;
        preempted_task_o <= preempt ? TASK_W'(run_idx_q) : '0;
        released_mask_o  <= rel_q;
        dropped_mask_o   <= drop_q;
        completed_o      <= complete;
        response_time_o  <= complete ? WORD_W'(resp_t) : '0;
        late_o           <= complete && (done_t > best_ad_q);
      end
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

### sv/rms_edf_preemptive_task_scheduler.sv
// Periodic-task scheduler, rate monotonic or earliest deadline first.
// Input channel (in_valid_i / in_stall_o): one word is either a tick or a
// load of one task table entry (period, relative deadline, first release).
// Output channel (out_valid_o / out_stall_i): one result word per input
// word, in order; a load answers with an all-zero word.
// Configuration: cfg_we_i writes register cfg_index_i (0 mode, 1 number of
// participating tasks) from cfg_data_i; write only while the block is idle.
// Sequence: a load passes the capture, load and commit steps; a tick passes
// capture, a scan of the N participating table entries and commit, the scan
// visiting one table entry per cycle through a single table read port. With
// no participating task a tick goes from capture straight to commit. A new
// word is taken once the previous one has been committed, even while its
// result still waits.
// Reset clears time, job activity, the running task and both registers;
// table contents are undefined until loaded.
// A stalled receiver holds the result register; the block then takes at
// most one further word, works it through and waits at the commit step
// with in_stall_o high.
module rms_edf_preemptive_task_scheduler #(
  parameter int TASK_SLOTS = 8,
  parameter int TIME_BITS  = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic                              cfg_index_i,
  input  logic [rmsedf_pkg::CFG_W-1:0]      cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              action_i,
  input  logic [rmsedf_pkg::TASK_W-1:0]     task_index_i,
  input  logic [rmsedf_pkg::WORD_W-1:0]     task_period_i,
  input  logic [rmsedf_pkg::WORD_W-1:0]     task_deadline_i,
  input  logic [rmsedf_pkg::WORD_W-1:0]     first_release_i,
  input  logic                              job_done_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [rmsedf_pkg::TASK_W-1:0]     served_task_o,
  output logic                              idle_o,
  output logic                              preempted_o,
  output logic [rmsedf_pkg::TASK_W-1:0]     preempted_task_o,
  output logic [rmsedf_pkg::MASK_W-1:0]     released_mask_o,
  output logic [rmsedf_pkg::MASK_W-1:0]     dropped_mask_o,
  output logic                              completed_o,
  output logic [rmsedf_pkg::WORD_W-1:0]     response_time_o,
  output logic                              late_o
);
  import rmsedf_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  // sequence capture, load or scan, then commit
  rmsedf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // task table, job state, priority scan and result register
  rmsedf_dp #(
    .TASK_SLOTS (TASK_SLOTS),
    .TIME_BITS  (TIME_BITS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .action_i         (action_i),
    .task_index_i     (task_index_i),
    .task_period_i    (task_period_i),
    .task_deadline_i  (task_deadline_i),
    .first_release_i  (first_release_i),
    .job_done_i       (job_done_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .served_task_o    (served_task_o),
    .idle_o           (idle_o),
    .preempted_o      (preempted_o),
    .preempted_task_o (preempted_task_o),
    .released_mask_o  (released_mask_o),
    .dropped_mask_o   (dropped_mask_o),
    .completed_o      (completed_o),
    .response_time_o  (response_time_o),
    .late_o           (late_o)
  );

endmodule

### tb/tb_rms_edf_preemptive_task_scheduler.sv
module tb_rms_edf_preemptive_task_scheduler;
  timeunit 1ns;
  timeprecision 1ps;

  import rmsedf_pkg::*;

  localparam int SLOTS        = 8;
  localparam int DRAIN_CYCLES = 12;   // covers the longest tick, with a scan of all eight entries
  localparam int HOLD_CYCLES  = 200;  // long receiver hold-off for the pressure test

  // One input word as the sender sees it
  typedef struct packed {
    logic              action;
    logic [TASK_W-1:0] idx;
    logic [WORD_W-1:0] period;
    logic [WORD_W-1:0] deadline;
    logic [WORD_W-1:0] first_rel;
    logic              done;
  } sched_word_t;

  // One result word, field for field as on the output port
  typedef struct packed {
    logic [TASK_W-1:0] served;
    logic              idle;
    logic              preempted;
    logic [TASK_W-1:0] victim;
    logic [MASK_W-1:0] released;
    logic [MASK_W-1:0] dropped;
    logic              completed;
    logic [WORD_W-1:0] resp;
    logic              late;
  } sched_result_t;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic              cfg_index_i;
  logic [CFG_W-1:0]  cfg_data_i;
  logic              in_valid_i;
  logic              in_stall_o;
  logic              action_i;
  logic [TASK_W-1:0] task_index_i;
  logic [WORD_W-1:0] task_period_i;
  logic [WORD_W-1:0] task_deadline_i;
  logic [WORD_W-1:0] first_release_i;
  logic              job_done_i;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [TASK_W-1:0] served_task_o;
  logic              idle_o;
  logic              preempted_o;
  logic [TASK_W-1:0] preempted_task_o;
  logic [MASK_W-1:0] released_mask_o;
  logic [MASK_W-1:0] dropped_mask_o;
  logic              completed_o;
  logic [WORD_W-1:0] response_time_o;
  logic              late_o;

  rms_edf_preemptive_task_scheduler dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .action_i         (action_i),
    .task_index_i     (task_index_i),
    .task_period_i    (task_period_i),
    .task_deadline_i  (task_deadline_i),
    .first_release_i  (first_release_i),
    .job_done_i       (job_done_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .served_task_o    (served_task_o),
    .idle_o           (idle_o),
    .preempted_o      (preempted_o),
    .preempted_task_o (preempted_task_o),
    .released_mask_o  (released_mask_o),
    .dropped_mask_o   (dropped_mask_o),
    .completed_o      (completed_o),
    .response_time_o  (response_time_o),
    .late_o           (late_o)
  );

  // ---------------------------------------------------------------------
  // Scheduler mirror: its own copy of the task table, job state and the
  // two registers. Tables start at zero here, but the stimulus never lets
  // a tick look at an entry that has not been loaded.
  // ---------------------------------------------------------------------
  logic [WORD_W-1:0] now_tick = '0;
  logic [WORD_W-1:0] per_tab  [SLOTS] = '{default: '0};
  logic [WORD_W-1:0] dl_tab   [SLOTS] = '{default: '0};
  logic [WORD_W-1:0] next_rel [SLOTS] = '{default: '0};
  logic [WORD_W-1:0] rel_tick [SLOTS] = '{default: '0};
  logic [WORD_W-1:0] abs_dl   [SLOTS] = '{default: '0};
  logic              job_act  [SLOTS] = '{default: 1'b0};
  bit                run_valid = 1'b0;
  int unsigned       run_task  = 15;
  logic              mode_q    = MODE_RM;
  logic [CFG_W-1:0]  count_q   = '0;

  sched_result_t     schedule_q[$];   // results still owed by the block

  // Run bookkeeping
  int mismatches   = 0;
  int tick_count   = 0;
  int load_count   = 0;
  int finish_count = 0;
  int late_count   = 0;
  int preempt_count = 0;
  int drop_count   = 0;

  // Idling controls, set by the test tasks
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int hold_requests = 0;   // bumped by a test to ask for one long hold-off
  int hold_served   = 0;
  int hold_left     = 0;

  // Add with saturation at the top of the time range
  function automatic logic [WORD_W-1:0] sat_sum(input logic [WORD_W-1:0] a,
                                               input logic [WORD_W-1:0] b);
    logic [WORD_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[WORD_W] ? {WORD_W{1'b1}} : s[WORD_W-1:0];
  endfunction

  // Priority order: shorter period or earlier deadline, lower index on a tie
  function automatic bit outranks(input int cand, input int cur);
    if (mode_q == MODE_RM) begin
      if (per_tab[cand] != per_tab[cur]) return per_tab[cand] < per_tab[cur];
    end else if (abs_dl[cand] != abs_dl[cur]) begin
      return abs_dl[cand] < abs_dl[cur];
    end
    return cand < cur;
  endfunction

  // Advance the mirror by one accepted word and return the result it owes
  function automatic sched_result_t schedule_word(input sched_word_t w);
    sched_result_t     r;
    int                cnt;
    int                sel;
    bit                have;
    logic [WORD_W-1:0] done_tick;
    r    = '0;
    sel  = 0;
    have = 1'b0;
    if (w.action == ACT_LOAD) begin
      per_tab[w.idx]  = w.period;
      dl_tab[w.idx]   = w.deadline;
      next_rel[w.idx] = w.first_rel;
      job_act[w.idx]  = 1'b0;
      load_count++;
      return r;
    end
    tick_count++;
    cnt = (count_q > SLOTS) ? SLOTS : int'(count_q);
    // Release every due job; drop the old one if it never finished
    for (int i = 0; i < cnt; i++) begin
      if (now_tick == next_rel[i]) begin
        if (job_act[i]) begin
          r.dropped[i] = 1'b1;
          drop_count++;
        end
        job_act[i]  = 1'b1;
        rel_tick[i] = now_tick;
        abs_dl[i]   = sat_sum(now_tick, dl_tab[i]);
        next_rel[i] = sat_sum(next_rel[i], per_tab[i]);
        r.released[i] = 1'b1;
      end
    end
    // Pick the best ready job
    for (int i = 0; i < cnt; i++) begin
      if (job_act[i] && rel_tick[i] <= now_tick) begin
        if (!have || outranks(i, sel)) begin
          sel  = i;
          have = 1'b1;
        end
      end
    end
    if (run_valid && have && run_task != sel && run_task < SLOTS && job_act[run_task]) begin
      r.preempted = 1'b1;
      r.victim    = run_task[TASK_W-1:0];
      preempt_count++;
    end
    run_valid = have;
    run_task  = have ? sel : 15;
    if (!have) begin
      r.idle = 1'b1;
    end else begin
      r.served = sel[TASK_W-1:0];
      if (w.done) begin
        done_tick   = sat_sum(now_tick, 1);
        r.completed = 1'b1;
        r.resp      = done_tick - rel_tick[sel];
        r.late      = done_tick > abs_dl[sel];
        job_act[sel] = 1'b0;
        run_valid   = 1'b0;
        run_task    = 15;
        finish_count++;
        if (r.late) late_count++;
      end
    end
    now_tick = sat_sum(now_tick, 1);
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Word builders. Fields that the action ignores carry random filler so
  // that every input bit toggles.
  // ---------------------------------------------------------------------
  function automatic sched_word_t make_tick(input logic done);
    sched_word_t w;
    w.action    = ACT_TICK;
    w.idx       = TASK_W'($urandom_range(SLOTS - 1));
    w.period    = $urandom();
    w.deadline  = $urandom();
    w.first_rel = $urandom();
    w.done      = done;
    return w;
  endfunction

  function automatic sched_word_t make_load(input int idx, input logic [WORD_W-1:0] period,
                                            input logic [WORD_W-1:0] deadline,
                                            input logic [WORD_W-1:0] first_rel);
    sched_word_t w;
    w.action    = ACT_LOAD;
    w.idx       = idx[TASK_W-1:0];
    w.period    = period;
    w.deadline  = deadline;
    w.first_rel = first_rel;
    w.done      = 1'($urandom_range(1));
    return w;
  endfunction

  // Mostly short spans so that jobs collide; now and then the extremes
  function automatic logic [WORD_W-1:0] pick_span(input int hi);
    logic [WORD_W-1:0] v;
    case ($urandom_range(19))
      0: v = {WORD_W{1'b1}};
      1: v = $urandom();
      2: v = 1;
      default: v = $urandom_range(hi, 2);
    endcase
    return (v == 0) ? 1 : v;
  endfunction

  function automatic sched_word_t random_word();
    logic [WORD_W-1:0] start;
    if ($urandom_range(99) < 15) begin
      // Release soon after the current tick so the entry takes part again
      start = ($urandom_range(19) == 0) ? WORD_W'($urandom())
                                         : sat_sum(now_tick, $urandom_range(12));
      return make_load($urandom_range(SLOTS - 1), pick_span(16), pick_span(20), start);
    end
    return make_tick($urandom_range(99) < 40);
  endfunction

  // ---------------------------------------------------------------------
  // Shared sender: idle for a random while, offer the word, hold it until
  // the block takes it, then book the result it owes.
  // ---------------------------------------------------------------------
  task automatic send_word(input sched_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i      <= 1'b1;
    action_i        <= w.action;
    task_index_i    <= w.idx;
    task_period_i   <= w.period;
    task_deadline_i <= w.deadline;
    first_release_i <= w.first_rel;
    job_done_i      <= w.done;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    schedule_q.push_back(schedule_word(w));
  endtask

  // Withdraw the offer, then wait until every owed word has come back
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (schedule_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic idx, input logic [CFG_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    if (idx == CFG_MODE) mode_q = data[0];
    else count_q = data;
  endtask

  // Registers change only with the block empty
  task automatic configure(input logic mode, input logic [CFG_W-1:0] count);
    drain();
    cfg_write(CFG_MODE, {{(CFG_W - 1){1'b0}}, mode});
    cfg_write(CFG_COUNT, count);
  endtask

  task automatic run_random(input int n);
    repeat (n) send_word(random_word());
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Hand-placed words: idle ticks with no task taking part, loads with the
  // field extremes, then ticks under both policies with releases, preemption,
  // late and saturating deadlines
  task automatic test_directed();
    logic [WORD_W-1:0] t0;
    localparam logic [WORD_W-1:0] TOP = {WORD_W{1'b1}};
    send_idle_pct = 0;
    stall_pct     = 0;
    send_word(make_tick(1'b1));   // nothing takes part: job done is ignored
    send_word(make_tick(1'b0));
    t0 = now_tick;
    send_word(make_load(0, TOP, TOP, sat_sum(t0, 3)));
    send_word(make_load(1, 6, 3, sat_sum(t0, 2)));
    send_word(make_load(2, 4, 10, t0));
    send_word(make_load(3, TOP, TOP, t0));
    send_word(make_load(4, 1, 1, sat_sum(t0, 1)));
    send_word(make_load(5, 2, TOP, sat_sum(t0, 1)));
    send_word(make_load(6, 3, 5, sat_sum(t0, 4)));
    send_word(make_load(7, 5, 2, '0));   // first release already past
    configure(MODE_RM, 4);
    send_word(make_tick(1'b0));
    send_word(make_tick(1'b0));
    send_word(make_tick(1'b1));
    send_word(make_tick(1'b0));
    send_word(make_tick(1'b0));
    send_word(make_tick(1'b1));
    send_word(make_tick(1'b1));
    configure(MODE_EDF, 8);
    send_word(make_tick(1'b0));
    send_word(make_tick(1'b1));
    send_word(make_tick(1'b0));
    send_word(make_tick(1'b0));
    send_word(make_tick(1'b1));
    send_word(make_tick(1'b1));
  endtask

  task automatic test_no_idling();
    configure(MODE_RM, 8);
    send_idle_pct = 0;
    stall_pct     = 0;
    run_random(250);
  endtask

  task automatic test_sender_gaps();
    configure(MODE_EDF, 8);
    send_idle_pct = 73;
    stall_pct     = 0;
    run_random(200);
  endtask

  // Count beyond the table size: the block must cap it at eight
  task automatic test_receiver_stalls();
    configure(MODE_RM, 15);
    send_idle_pct = 0;
    stall_pct     = 73;
    run_random(200);
  endtask

  task automatic test_both_idle();
    configure(MODE_EDF, 9);
    send_idle_pct = 17;
    stall_pct     = 17;
    run_random(200);
  endtask

  task automatic test_single_task();
    configure(MODE_RM, 1);
    send_idle_pct = 0;
    stall_pct     = 0;
    run_random(60);
  endtask

  task automatic test_partial_table();
    configure(MODE_EDF, 5);
    send_idle_pct = 17;
    stall_pct     = 17;
    run_random(150);
  endtask

  // Hold the receiver off for a long stretch while words keep coming, so
  // the result register fills and the input stalls
  task automatic test_backpressure();
    configure(MODE_RM, 8);
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_requests++;
    run_random(40);
  endtask

  // ---------------------------------------------------------------------
  // Clock, reset and top-level sequence
  // ---------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_index_i     = CFG_MODE;
    cfg_data_i      = '0;
    in_valid_i      = 1'b0;
    action_i        = ACT_TICK;
    task_index_i    = '0;
    task_period_i   = '0;
    task_deadline_i = '0;
    first_release_i = '0;
    job_done_i      = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_no_idling();
    test_sender_gaps();
    test_receiver_stalls();
    test_both_idle();
    test_single_task();
    test_partial_table();
    test_backpressure();
    drain();

    $display("covered %0d ticks and %0d loads under both policies, counts 0 to 15",
             tick_count, load_count);
    $display("saw %0d completions (%0d late), %0d preemptions, %0d dropped jobs; %0d mismatches",
             finish_count, late_count, preempt_count, drop_count, mismatches);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Hard limit, several times the slowest correct run
  initial begin
    #(5_000_000);
    $display("tb: timeout with %0d results outstanding", schedule_q.size());
    $display("tb: failure");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Receiver: random stalls, plus one long hold-off when a test asks
  // ---------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left   = HOLD_CYCLES - 1;
      out_stall_i <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // Compare every accepted result word with the oldest owed one
  always @(posedge clk_i) begin : check_result
    sched_result_t got;
    sched_result_t want;
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      got = '{served: served_task_o, idle: idle_o, preempted: preempted_o,
              victim: preempted_task_o, released: released_mask_o,
              dropped: dropped_mask_o, completed: completed_o,
              resp: response_time_o, late: late_o};
      if (schedule_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%t: result word with nothing owed: served %0d idle %0b", $realtime,
                   got.served, got.idle);
      end else begin
        want = schedule_q.pop_front();
        if (got.served !== want.served || got.idle !== want.idle ||
            got.preempted !== want.preempted || got.victim !== want.victim ||
            got.released !== want.released || got.dropped !== want.dropped ||
            got.completed !== want.completed || got.resp !== want.resp ||
            got.late !== want.late) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%t: mismatch, expected srv %0d idle %0b pre %0b/%0d rel %h drop %h",
                     $realtime, want.served, want.idle, want.preempted, want.victim,
                     want.released, want.dropped);
            $display("    done %0b resp %0d late %0b; got srv %0d idle %0b pre %0b/%0d",
                     want.completed, want.resp, want.late, got.served, got.idle,
                     got.preempted, got.victim);
            $display("    rel %h drop %h done %0b resp %0d late %0b",
                     got.released, got.dropped, got.completed, got.resp, got.late);
          end
        end
      end
    end
  end

endmodule

### files.f
sv/rmsedf_pkg.sv
sv/rmsedf_ctrl.sv
sv/rmsedf_dp.sv
sv/rms_edf_preemptive_task_scheduler.sv
tb/tb_rms_edf_preemptive_task_scheduler.sv
